[rtl/fractional_max_pool_1d_unit_macros.svh]
// Assertion macros shared by the fractional max pooling unit.
`ifndef FRACTIONAL_MAX_POOL_1D_UNIT_MACROS_SVH
`define FRACTIONAL_MAX_POOL_1D_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define FMP_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define FMP_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/fmp_pkg.sv]
`default_nettype none

package fmp_pkg;

    // Defaults for the top-level parameters.
    localparam int MAX_LEN_DEF      = 64;
    localparam int SAMPLE_WIDTH_DEF = 32;

    // Register widths and reset values.
    localparam int LEN_W = 7;
    localparam int U_W   = 16;
    localparam int IDX_W = 6;
    localparam logic [LEN_W-1:0] IN_LEN_RST    = 7'd10;
    localparam logic [LEN_W-1:0] OUT_LEN_RST   = 7'd7;
    localparam logic [LEN_W-1:0] POOL_SIZE_RST = 7'd2;
    localparam logic [U_W-1:0]   OFFSET_U_RST  = 16'd32768;
    localparam logic [LEN_W-1:0] LEN_MIN       = 7'd2;
    localparam int OUT_CAP = 64;

    // Boundary arithmetic widths.
    localparam int SPAN_W = 8;   // signed span in_len - pool_size
    localparam int DIVD_W = 8;   // dividend of the shared divider
    localparam int DIVS_W = 6;   // divisor out_len - 1
    localparam int DCNT_W = 3;   // divider step counter
    localparam int QW     = 14;  // running boundary quotient

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_IN_LEN    = 2'd0,
        CFG_OUT_LEN   = 2'd1,
        CFG_POOL_SIZE = 2'd2,
        CFG_OFFSET_U  = 2'd3
    } t_cfg_idx;

    // Controller states.
    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SCALE,
        ST_DIV_SPAN,
        ST_DIV_BASE,
        ST_READ,
        ST_CAPTURE,
        ST_OUT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic scale;
        logic div_start;
        logic div_sel_base;
        logic latch_ab;
        logic latch_base;
        logic read;
        logic capture;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic frame_done;
        logic div_done;
        logic last;
    } t_status;

endpackage

`default_nettype wire

[rtl/fmp_div.sv]
`default_nettype none
`include "fractional_max_pool_1d_unit_macros.svh"

// Restoring divider, one quotient bit per cycle.
module fmp_div import fmp_pkg::*; (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_start,
    input  wire [DIVD_W-1:0]   i_dividend,
    input  wire [DIVS_W-1:0]   i_divisor,
    output logic               o_done,
    output logic [DIVD_W-1:0]  o_quotient,
    output logic [DIVS_W-1:0]  o_remainder
);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [DCNT_W-1:0] r_cnt, n_cnt;
    logic [DIVD_W-1:0] r_quo, n_quo;
    logic [DIVS_W-1:0] r_rem, n_rem;
    logic [DIVS_W-1:0] r_dsr;
    logic [DIVS_W:0]   rem_shift;
    logic              fits;

    // One trial subtraction per cycle.
    always_comb begin
        rem_shift = {r_rem, r_quo[DIVD_W-1]};
        fits      = rem_shift >= {1'b0, r_dsr};
        n_busy    = r_busy;
        n_done    = 1'b0;
        n_cnt     = r_cnt;
        n_quo     = r_quo;
        n_rem     = r_rem;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = DCNT_W'(DIVD_W - 1);
            n_quo  = i_dividend;
            n_rem  = '0;
        end else if (r_busy) begin
            n_quo = {r_quo[DIVD_W-2:0], fits};
            n_rem = fits ? DIVS_W'(rem_shift - {1'b0, r_dsr}) : rem_shift[DIVS_W-1:0];
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // Operands and partial results.
    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
        if (i_start) begin
            r_dsr <= i_divisor;
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

    `FMP_ASSERT_IMP(a_start_when_free, i_clk, i_rst_n, i_start, !r_busy, "divider restarted while busy")
    `FMP_ASSERT_NXT(a_done_ends_busy, i_clk, i_rst_n, r_busy && (r_cnt == '0) && !i_start, r_done && !r_busy, "divider did not finish")

endmodule

`default_nettype wire

[rtl/fmp_ctrl.sv]
`default_nettype none
`include "fractional_max_pool_1d_unit_macros.svh"

// Frame sequencer: loading, boundary set-up and result emission.
module fmp_ctrl import fmp_pkg::*; (
    input  wire      i_clk,
    input  wire      i_rst_n,
    input  wire      i_sample_valid,
    input  wire      i_result_ready,
    input  t_status  i_status,
    output t_cmd     o_cmd,
    output logic     o_sample_ready,
    output logic     o_result_valid
);

    t_state r_state, n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD: begin
                if (i_sample_valid && i_status.frame_done) begin
                    n_state = ST_SCALE;
                end
            end
            ST_SCALE: begin
                n_state = ST_DIV_SPAN;
            end
            ST_DIV_SPAN: begin
                if (i_status.div_done) begin
                    n_state = ST_DIV_BASE;
                end
            end
            ST_DIV_BASE: begin
                if (i_status.div_done) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_CAPTURE;
            end
            ST_CAPTURE: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (i_result_ready) begin
                    n_state = i_status.last ? ST_LOAD : ST_READ;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    // Outputs and datapath commands.
    always_comb begin
        o_cmd          = '0;
        o_sample_ready = 1'b0;
        o_result_valid = 1'b0;
        unique case (r_state)
            ST_LOAD: begin
                o_sample_ready = 1'b1;
                o_cmd.load     = i_sample_valid;
            end
            ST_SCALE: begin
                o_cmd.scale     = 1'b1;
                o_cmd.div_start = 1'b1;
            end
            ST_DIV_SPAN: begin
                if (i_status.div_done) begin
                    o_cmd.latch_ab     = 1'b1;
                    o_cmd.div_start    = 1'b1;
                    o_cmd.div_sel_base = 1'b1;
                end
            end
            ST_DIV_BASE: begin
                o_cmd.latch_base = i_status.div_done;
            end
            ST_READ: begin
                o_cmd.read = 1'b1;
            end
            ST_CAPTURE: begin
                o_cmd.capture = 1'b1;
            end
            ST_OUT: begin
                o_result_valid = 1'b1;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    `FMP_ASSERT_IMP(a_one_side_open, i_clk, i_rst_n, o_sample_ready, !o_result_valid, "loading and emitting at once")
    `FMP_ASSERT_NXT(a_last_back_to_load, i_clk, i_rst_n, o_result_valid && i_result_ready && i_status.last, o_sample_ready, "frame end did not return to loading")
    `FMP_ASSERT_IMP(a_done_expected, i_clk, i_rst_n, i_status.div_done, (r_state == ST_DIV_SPAN) || (r_state == ST_DIV_BASE), "division finished outside set-up")

endmodule

`default_nettype wire

[rtl/fmp_dpath.sv]
`default_nettype none
`include "fractional_max_pool_1d_unit_macros.svh"

// Sample store, configuration registers and incremental boundary arithmetic.
module fmp_dpath import fmp_pkg::*; #(
    parameter int MAX_LEN      = MAX_LEN_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_cfg_we,
    input  wire [1:0]                i_cfg_index,
    input  wire [U_W-1:0]            i_cfg_wdata,
    input  wire [SAMPLE_WIDTH-1:0]   i_sample,
    input  t_cmd                     i_cmd,
    output t_status                  o_status,
    output logic [SAMPLE_WIDTH-1:0]  o_max_value,
    output logic [IDX_W-1:0]         o_left_index,
    output logic [IDX_W-1:0]         o_right_index,
    output logic                     o_last_result
);

    localparam int IW     = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int IN_HI  = (MAX_LEN < 127) ? MAX_LEN : 127;
    localparam int OUT_HI = (MAX_LEN < OUT_CAP) ? MAX_LEN : OUT_CAP;

    // Configuration registers.
    logic [LEN_W-1:0] r_in_len, r_out_len, r_pool_size;
    logic [U_W-1:0]   r_offset_u;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_len    <= IN_LEN_RST;
            r_out_len   <= OUT_LEN_RST;
            r_pool_size <= POOL_SIZE_RST;
            r_offset_u  <= OFFSET_U_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_IN_LEN:    r_in_len    <= i_cfg_wdata[LEN_W-1:0];
                CFG_OUT_LEN:   r_out_len   <= i_cfg_wdata[LEN_W-1:0];
                CFG_POOL_SIZE: r_pool_size <= i_cfg_wdata[LEN_W-1:0];
                CFG_OFFSET_U:  r_offset_u  <= i_cfg_wdata;
                default:       r_in_len    <= r_in_len;
            endcase
        end
    end

    // Effective lengths, span and divisor.
    logic [LEN_W-1:0]        n_in, n_out, n_in_m1;
    logic [DIVS_W-1:0]       dsr;
    logic signed [SPAN_W-1:0] span;
    logic                    span_pos;
    logic [LEN_W-1:0]        span_mag;

    always_comb begin
        if (r_in_len < LEN_MIN) begin
            n_in = LEN_MIN;
        end else if (int'(r_in_len) > IN_HI) begin
            n_in = LEN_W'(IN_HI);
        end else begin
            n_in = r_in_len;
        end
        if (r_out_len < LEN_MIN) begin
            n_out = LEN_MIN;
        end else if (int'(r_out_len) > OUT_HI) begin
            n_out = LEN_W'(OUT_HI);
        end else begin
            n_out = r_out_len;
        end
        n_in_m1  = n_in - 1'b1;
        dsr      = DIVS_W'(n_out - 1'b1);
        span     = $signed({1'b0, n_in}) - $signed({1'b0, r_pool_size});
        span_pos = !span[SPAN_W-1] && (span != '0);
        span_mag = span[LEN_W-1:0];
    end

    // Load counter and sample store.
    logic [LEN_W-1:0]        r_load_count;
    logic                    frame_done;
    logic [SAMPLE_WIDTH-1:0] r_mem [MAX_LEN];

    assign frame_done = ({1'b0, r_load_count} + 8'd1) >= {1'b0, n_in};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_count <= '0;
        end else if (i_cmd.load) begin
            r_load_count <= frame_done ? '0 : r_load_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && (int'(r_load_count) < MAX_LEN)) begin
            r_mem[IW'(r_load_count)] <= i_sample;
        end
    end

    // Offset term: ceil(span * u / 2^16).
    logic [DIVD_W-1:0] r_c;
    logic [23:0]       scaled;

    assign scaled = ({17'b0, span_mag} * {8'b0, r_offset_u}) + 24'hFFFF;

    always_ff @(posedge i_clk) begin
        if (i_cmd.scale) begin
            r_c <= scaled[23:16];
        end
    end

    // Shared divider: span / d first, then the first boundary numerator.
    logic              div_done;
    logic [DIVD_W-1:0] div_quo;
    logic [DIVS_W-1:0] div_rem;
    logic [DIVD_W-1:0] dividend;

    assign dividend = i_cmd.div_sel_base ? ({1'b0, span_mag} + r_c) : {1'b0, span_mag};

    fmp_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.div_start),
        .i_dividend  (dividend),
        .i_divisor   (dsr),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    // Running boundary numerator held as quotient and remainder by d.
    logic [DIVD_W-1:0] r_a;
    logic [DIVS_W-1:0] r_b;
    logic [QW-1:0]     r_qf;
    logic [DIVS_W-1:0] r_rem;
    logic [DIVS_W:0]   rem_sum;
    logic              rem_wrap;
    logic [QW-1:0]     q_ceil, q_m1, bnd;
    logic [IW-1:0]     right_idx;

    always_comb begin
        rem_sum   = {1'b0, r_rem} + {1'b0, r_b};
        rem_wrap  = rem_sum >= {1'b0, dsr};
        q_ceil    = r_qf + QW'(r_rem != '0);
        q_m1      = q_ceil - 1'b1;
        bnd       = (q_m1 > {{(QW-LEN_W){1'b0}}, n_in_m1}) ?
                    {{(QW-LEN_W){1'b0}}, n_in_m1} : q_m1;
        right_idx = span_pos ? IW'(bnd) : '0;
    end

    // Result sequencing registers.
    logic [IDX_W-1:0]        r_left;
    logic [IW-1:0]           r_right;
    logic [DIVS_W-1:0]       r_k;
    logic [SAMPLE_WIDTH-1:0] r_rd_left, r_rd_right;

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_ab) begin
            r_a <= div_quo;
            r_b <= div_rem;
        end
        if (i_cmd.latch_base) begin
            r_qf   <= {{(QW-DIVD_W){1'b0}}, div_quo};
            r_rem  <= div_rem;
            r_left <= '0;
            r_k    <= '0;
        end else if (i_cmd.read) begin
            r_qf    <= r_qf + {{(QW-DIVD_W){1'b0}}, r_a} + QW'(rem_wrap);
            r_rem   <= rem_wrap ? DIVS_W'(rem_sum - {1'b0, dsr}) : rem_sum[DIVS_W-1:0];
            r_right <= right_idx;
        end else if (i_cmd.capture) begin
            r_left <= IDX_W'(r_right);
            r_k    <= r_k + 1'b1;
        end
    end

    // Registered store reads at both boundaries.
    always_ff @(posedge i_clk) begin
        if (i_cmd.read) begin
            r_rd_left  <= r_mem[IW'(r_left)];
            r_rd_right <= r_mem[right_idx];
        end
    end

    // Output register.
    logic [SAMPLE_WIDTH-1:0] r_out_max;
    logic [IDX_W-1:0]        r_out_left, r_out_right;
    logic                    r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_last <= 1'b0;
        end else if (i_cmd.capture) begin
            r_out_last <= (r_k == dsr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_out_max   <= ($signed(r_rd_left) > $signed(r_rd_right)) ? r_rd_left : r_rd_right;
            r_out_left  <= r_left;
            r_out_right <= IDX_W'(r_right);
        end
    end

    assign o_max_value         = r_out_max;
    assign o_left_index        = r_out_left;
    assign o_right_index       = r_out_right;
    assign o_last_result       = r_out_last;
    assign o_status.frame_done = frame_done;
    assign o_status.div_done   = div_done;
    assign o_status.last       = r_out_last;

    `FMP_ASSERT_IMP(a_right_in_frame, i_clk, i_rst_n, i_cmd.capture, int'(r_right) < int'(n_in), "boundary beyond frame")

endmodule

`default_nettype wire

[rtl/fractional_max_pool_1d_unit.sv]
// Fractional max pooling over one frame of signed samples.
// Samples enter on the request channel i_sample_valid / o_sample_ready, one per
// cycle while loading. Results leave on o_result_valid / i_result_ready; each
// carries the larger sample of a boundary pair, both boundary indexes and a
// last mark on the final result of the frame. Registers are written through
// i_cfg_we / i_cfg_index / i_cfg_wdata; the user writes them only while no
// frame is being emitted, which the block itself does not enforce. After the
// last sample of a frame the block sets up the boundaries, with a scaling step
// and two passes of an eight-step restoring divider, before the first result
// is valid. Once a result is taken, the next one passes through a registered
// store read at both boundaries and then a compare into the output register,
// so the block does not start on the next result before the current one is
// taken. The sample channel is closed while a frame is being set up or emitted.
// A stalled receiver simply holds the current result in the output register.
// Synchronous reset clears the controller, the load count and the registers
// to their defaults; the sample store needs no clearing.
`default_nettype none

module fractional_max_pool_1d_unit import fmp_pkg::*; #(
    parameter int MAX_LEN      = MAX_LEN_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_cfg_we,
    input  wire [1:0]                i_cfg_index,
    input  wire [U_W-1:0]            i_cfg_wdata,
    input  wire                      i_sample_valid,
    output logic                     o_sample_ready,
    input  wire [SAMPLE_WIDTH-1:0]   i_sample,
    output logic                     o_result_valid,
    input  wire                      i_result_ready,
    output logic [SAMPLE_WIDTH-1:0]  o_max_value,
    output logic [IDX_W-1:0]         o_left_index,
    output logic [IDX_W-1:0]         o_right_index,
    output logic                     o_last_result
);

    t_cmd    cmd;
    t_status status;

    // Sequencer.
    fmp_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_sample_valid (i_sample_valid),
        .i_result_ready (i_result_ready),
        .i_status       (status),
        .o_cmd          (cmd),
        .o_sample_ready (o_sample_ready),
        .o_result_valid (o_result_valid)
    );

    // Store and arithmetic.
    fmp_dpath #(
        .MAX_LEN      (MAX_LEN),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_sample      (i_sample),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_max_value   (o_max_value),
        .o_left_index  (o_left_index),
        .o_right_index (o_right_index),
        .o_last_result (o_last_result)
    );

endmodule

`default_nettype wire

[sim/tb_fractional_max_pool_1d_unit.sv]
`timescale 1ns / 100ps

module tb_fractional_max_pool_1d_unit import fmp_pkg::*; ();

    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 11;
    localparam int NUM_ITEMS     = 370;
    localparam int SETTLE_CYCLES = 32;
    localparam int STALL_LIMIT   = 2000;
    localparam int MAX_REPORTS   = 10;
    localparam int STORE_DEPTH   = 64;
    localparam int SAMPLE_W      = 32;
    localparam int PAD_W         = U_W - LEN_W;

    // One pooled result as it leaves the block.
    typedef struct packed {
        logic [SAMPLE_W-1:0] max_value;
        logic [IDX_W-1:0]    left_index;
        logic [IDX_W-1:0]    right_index;
        logic                last_result;
    } t_pool_result;

    // Kinds of row in the directed stimulus table.
    typedef enum logic [1:0] {
        ROW_CONFIG,
        ROW_IN_LEN,
        ROW_RESULT,
        ROW_SAMPLE
    } t_row_kind;

    typedef struct packed {
        t_row_kind           kind;
        logic [LEN_W-1:0]    in_len;
        logic [LEN_W-1:0]    out_len;
        logic [LEN_W-1:0]    pool_size;
        logic [U_W-1:0]      offset_u;
        logic [SAMPLE_W-1:0] sample;
        t_pool_result        result;
    } t_stim_row;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [1:0]          i_cfg_index;
    logic [U_W-1:0]      i_cfg_wdata;
    logic                i_sample_valid;
    logic                o_sample_ready;
    logic [SAMPLE_W-1:0] i_sample;
    logic                o_result_valid;
    logic                i_result_ready;
    logic [SAMPLE_W-1:0] o_max_value;
    logic [IDX_W-1:0]    o_left_index;
    logic [IDX_W-1:0]    o_right_index;
    logic                o_last_result;

    fractional_max_pool_1d_unit u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_sample_valid (i_sample_valid),
        .o_sample_ready (o_sample_ready),
        .i_sample       (i_sample),
        .o_result_valid (o_result_valid),
        .i_result_ready (i_result_ready),
        .o_max_value    (o_max_value),
        .o_left_index   (o_left_index),
        .o_right_index  (o_right_index),
        .o_last_result  (o_last_result)
    );

    // Shadow copy of the registers and the sample store.
    logic [LEN_W-1:0]    cfg_in_len;
    logic [LEN_W-1:0]    cfg_out_len;
    logic [LEN_W-1:0]    cfg_pool_size;
    logic [U_W-1:0]      cfg_offset_u;
    logic [SAMPLE_W-1:0] sample_mem [STORE_DEPTH];
    int unsigned         frame_fill;

    t_pool_result pooled_q[$];
    t_pool_result typed_q[$];
    t_stim_row    directed_rows[$];

    int                  samples_taken;
    int                  frames_done;
    int                  results_checked;
    int                  mismatch_count;
    int                  stall_cycles;
    int                  send_idle_pct;
    int                  recv_idle_pct;
    logic [SAMPLE_W-1:0] prev_sample;

    always #HALF_PERIOD i_clk = ~i_clk;

    // The receiver drops ready at random, at the rate of the current phase.
    always @(negedge i_clk) begin
        i_result_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    function automatic int unsigned clamp_len(input logic [LEN_W-1:0] v, input int unsigned hi);
        if (v < LEN_MIN) return {{(32-LEN_W){1'b0}}, LEN_MIN};
        if (v > hi) return hi;
        return {{(32-LEN_W){1'b0}}, v};
    endfunction

    // Boundary k, taken as an exact rational ceiling and clamped into the frame.
    function automatic logic [IDX_W-1:0] boundary_at(input int unsigned k,
                                                     input int unsigned n_in,
                                                     input int unsigned n_out);
        longint span;
        longint num;
        longint den;
        longint q;
        span = longint'(n_in) - longint'(cfg_pool_size);
        num  = span * (longint'(k) * 65536 + longint'(cfg_offset_u));
        den  = (longint'(n_out) - 1) * 65536;
        if (num >= 0) q = (num + den - 1) / den;
        else q = -((-num) / den);
        q = q - 1;
        if (q < 0) q = 0;
        if (q > longint'(n_in) - 1) q = longint'(n_in) - 1;
        return IDX_W'(q);
    endfunction

    // Store one accepted sample; on the last of a frame, queue every pooled result.
    task automatic take_sample(input logic [SAMPLE_W-1:0] value);
        int unsigned      n_in;
        int unsigned      n_out;
        logic [IDX_W-1:0] left_b;
        logic [IDX_W-1:0] right_b;
        t_pool_result     r;
        n_in = clamp_len(cfg_in_len, STORE_DEPTH);
        if (frame_fill < STORE_DEPTH) sample_mem[frame_fill] = value;
        frame_fill = (frame_fill + 1) % 128;
        samples_taken++;
        if (frame_fill < n_in) return;
        frame_fill = 0;
        frames_done++;
        n_out = clamp_len(cfg_out_len, OUT_CAP);
        left_b = '0;
        for (int unsigned i = 0; i < n_out; i++) begin
            right_b = boundary_at(i + 1, n_in, n_out);
            r.max_value = ($signed(sample_mem[left_b]) > $signed(sample_mem[right_b])) ?
                          sample_mem[left_b] : sample_mem[right_b];
            r.left_index  = left_b;
            r.right_index = right_b;
            r.last_result = (i + 1 == n_out);
            // Hand-written expectations of the directed part take precedence.
            if (typed_q.size() != 0) r = typed_q.pop_front();
            pooled_q.push_back(r);
            left_b = right_b;
        end
    endtask

    task automatic check_result();
        t_pool_result got;
        t_pool_result want;
        got.max_value   = o_max_value;
        got.left_index  = o_left_index;
        got.right_index = o_right_index;
        got.last_result = o_last_result;
        results_checked++;
        if (pooled_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("Unexpected result: max %h left %0d right %0d last %0b",
                         got.max_value, got.left_index, got.right_index, got.last_result);
        end else begin
            want = pooled_q.pop_front();
            if (got.max_value !== want.max_value || got.left_index !== want.left_index ||
                got.right_index !== want.right_index ||
                got.last_result !== want.last_result) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS) begin
                    $display("Mismatch %0d: expected max %h left %0d right %0d last %0b",
                             results_checked, want.max_value, want.left_index,
                             want.right_index, want.last_result);
                    $display("    got max %h left %0d right %0d last %0b",
                             got.max_value, got.left_index, got.right_index,
                             got.last_result);
                end
            end
        end
    endtask

    // Monitor: register writes, accepted requests on both channels, progress count.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_in_len    = IN_LEN_RST;
            cfg_out_len   = OUT_LEN_RST;
            cfg_pool_size = POOL_SIZE_RST;
            cfg_offset_u  = OFFSET_U_RST;
            frame_fill    = 0;
            stall_cycles  = 0;
        end else begin
            stall_cycles = stall_cycles + 1;
            if (i_cfg_we) begin
                stall_cycles = 0;
                case (i_cfg_index)
                    CFG_IN_LEN:    cfg_in_len    = i_cfg_wdata[LEN_W-1:0];
                    CFG_OUT_LEN:   cfg_out_len   = i_cfg_wdata[LEN_W-1:0];
                    CFG_POOL_SIZE: cfg_pool_size = i_cfg_wdata[LEN_W-1:0];
                    CFG_OFFSET_U:  cfg_offset_u  = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (o_result_valid && i_result_ready) begin
                stall_cycles = 0;
                check_result();
            end
            if (i_sample_valid && o_sample_ready) begin
                stall_cycles = 0;
                take_sample(i_sample);
            end
        end
    end

    // Present one sample request and hold it until it is taken.
    task automatic send_sample(input logic [SAMPLE_W-1:0] value);
        if (samples_taken < NUM_ITEMS / 3) begin
            send_idle_pct = 33;
            recv_idle_pct = 56;
        end else if (samples_taken < 2 * NUM_ITEMS / 3) begin
            send_idle_pct = 56;
            recv_idle_pct = 33;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_sample_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_sample_valid <= 1'b1;
        i_sample       <= value;
        do @(posedge i_clk); while (!o_sample_ready);
        @(negedge i_clk);
        prev_sample = value;
    endtask

    // Close the sample channel until every pooled result is back and the block is quiet.
    task automatic wait_drained();
        i_sample_valid <= 1'b0;
        while (pooled_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [U_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // Length registers take random filler in the unused upper bits.
    function automatic logic [U_W-1:0] pad_len(input logic [LEN_W-1:0] v);
        return {PAD_W'($urandom), v};
    endfunction

    task automatic write_frame_cfg(input logic [LEN_W-1:0] in_len,
                                   input logic [LEN_W-1:0] out_len,
                                   input logic [LEN_W-1:0] pool_size,
                                   input logic [U_W-1:0] offset_u);
        write_reg(CFG_IN_LEN, pad_len(in_len));
        write_reg(CFG_OUT_LEN, pad_len(out_len));
        write_reg(CFG_POOL_SIZE, pad_len(pool_size));
        write_reg(CFG_OFFSET_U, offset_u);
    endtask

    // Mostly short frames, now and then long ones and lengths that saturate.
    function automatic logic [LEN_W-1:0] pick_len();
        case ($urandom_range(0, 19))
            0: return LEN_W'($urandom_range(0, 1));
            1: return LEN_W'($urandom_range(65, 127));
            2: return LEN_W'($urandom_range(33, 64));
            default: return LEN_W'($urandom_range(2, 12));
        endcase
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            1: return prev_sample;
            default: return $urandom;
        endcase
    endfunction

    // One frame with random settings, sometimes with a length change part way through.
    task automatic random_frame();
        logic [LEN_W-1:0] in_len;
        logic [LEN_W-1:0] pool_size;
        logic [U_W-1:0]   offset_u;
        int unsigned      n_in;
        int unsigned      change_at;
        in_len = pick_len();
        n_in   = clamp_len(in_len, STORE_DEPTH);
        case ($urandom_range(0, 9))
            0: pool_size = '0;
            1: pool_size = LEN_W'($urandom_range(n_in + 1, 127));
            default: pool_size = LEN_W'($urandom_range(1, n_in));
        endcase
        case ($urandom_range(0, 7))
            0: offset_u = '0;
            1: offset_u = '1;
            default: offset_u = U_W'($urandom);
        endcase
        wait_drained();
        write_frame_cfg(in_len, pick_len(), pool_size, offset_u);
        change_at = ($urandom_range(0, 7) == 0) ? $urandom_range(1, n_in - 1) : 0;
        do begin
            if (change_at != 0 && frame_fill == change_at) begin
                wait_drained();
                write_reg(CFG_IN_LEN, pad_len(pick_len()));
                change_at = 0;
            end
            send_sample(pick_sample());
        end while (frame_fill != 0);
    endtask

    function automatic t_stim_row cfg_row(input t_row_kind kind, input logic [LEN_W-1:0] in_len,
                                          input logic [LEN_W-1:0] out_len,
                                          input logic [LEN_W-1:0] pool_size,
                                          input logic [U_W-1:0] offset_u);
        t_stim_row row;
        row           = '0;
        row.kind      = kind;
        row.in_len    = in_len;
        row.out_len   = out_len;
        row.pool_size = pool_size;
        row.offset_u  = offset_u;
        return row;
    endfunction

    function automatic t_stim_row smp_row(input logic [SAMPLE_W-1:0] value);
        t_stim_row row;
        row        = '0;
        row.kind   = ROW_SAMPLE;
        row.sample = value;
        return row;
    endfunction

    function automatic t_stim_row res_row(input logic [SAMPLE_W-1:0] max_value,
                                          input logic [IDX_W-1:0] left_index,
                                          input logic [IDX_W-1:0] right_index,
                                          input logic last_result);
        t_stim_row row;
        row                    = '0;
        row.kind               = ROW_RESULT;
        row.result.max_value   = max_value;
        row.result.left_index  = left_index;
        row.result.right_index = right_index;
        row.result.last_result = last_result;
        return row;
    endfunction

    // A run that stops making progress is a failure.
    initial begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("Timeout: no request accepted for %0d cycles", STALL_LIMIT);
        $display("tb_fractional_max_pool_1d_unit failed");
        $finish;
    end

    initial begin
        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_index     = CFG_IN_LEN;
        i_cfg_wdata     = '0;
        i_sample_valid  = 1'b0;
        i_sample        = '0;
        i_result_ready  = 1'b0;
        samples_taken   = 0;
        frames_done     = 0;
        results_checked = 0;
        mismatch_count  = 0;
        stall_cycles    = 0;
        send_idle_pct   = 33;
        recv_idle_pct   = 56;
        prev_sample     = '0;
        foreach (sample_mem[i]) sample_mem[i] = '0;

        // Directed frames. The first runs on the reset settings, whose boundaries
        // are 0, 1, 3, 4, 5, 7, 8, 9. Then both lengths below the minimum with a
        // pool wider than the frame, the most results per frame, a full offset,
        // and a length cut below the samples already loaded part way through.
        directed_rows = '{
            res_row(32'h7FFF_FFFF, 6'd0, 6'd1, 1'b0),
            res_row(32'h7FFF_FFFF, 6'd1, 6'd3, 1'b0),
            res_row(32'h0000_0001, 6'd3, 6'd4, 1'b0),
            res_row(32'h0000_0000, 6'd4, 6'd5, 1'b0),
            res_row(32'h0000_0000, 6'd5, 6'd7, 1'b0),
            res_row(32'h7FFF_FFFE, 6'd7, 6'd8, 1'b0),
            res_row(32'h7FFF_FFFE, 6'd8, 6'd9, 1'b1),
            smp_row(32'h8000_0000), smp_row(32'h7FFF_FFFF), smp_row(32'hFFFF_FFFF),
            smp_row(32'h0000_0001), smp_row(32'h8000_0001), smp_row(32'h0000_0000),
            smp_row(32'h1234_5678), smp_row(32'hFFFF_0000), smp_row(32'h7FFF_FFFE),
            smp_row(32'h8000_0000),
            cfg_row(ROW_CONFIG, 7'd0, 7'd1, 7'd127, 16'hFFFF),
            res_row(32'h8000_0000, 6'd0, 6'd0, 1'b0),
            res_row(32'h8000_0000, 6'd0, 6'd0, 1'b1),
            smp_row(32'h8000_0000), smp_row(32'h7FFF_FFFF),
            cfg_row(ROW_CONFIG, 7'd1, 7'd127, 7'd0, 16'h0000),
            smp_row(32'h7FFF_FFFF), smp_row(32'h8000_0000),
            cfg_row(ROW_CONFIG, 7'd3, 7'd2, 7'd1, 16'hFFFF),
            smp_row(32'hAAAA_AAAA), smp_row(32'h5555_5555), smp_row(32'h8000_0000),
            cfg_row(ROW_CONFIG, 7'd5, 7'd4, 7'd64, 16'h0000),
            smp_row(32'h0000_0001), smp_row(32'h0000_0002), smp_row(32'h0000_0003),
            cfg_row(ROW_IN_LEN, 7'd2, 7'd0, 7'd0, 16'h0000),
            smp_row(32'hFFFF_FFFE)
        };

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[i]) begin
            case (directed_rows[i].kind)
                ROW_CONFIG: begin
                    wait_drained();
                    write_frame_cfg(directed_rows[i].in_len, directed_rows[i].out_len,
                                    directed_rows[i].pool_size, directed_rows[i].offset_u);
                end
                ROW_IN_LEN: begin
                    wait_drained();
                    write_reg(CFG_IN_LEN, pad_len(directed_rows[i].in_len));
                end
                ROW_RESULT: typed_q.push_back(directed_rows[i].result);
                default: send_sample(directed_rows[i].sample);
            endcase
        end

        // Random frames until the sample budget is used up.
        while (samples_taken < NUM_ITEMS) random_frame();

        wait_drained();
        $display("Ran %0d samples in %0d frames; %0d results compared, %0d mismatched.",
                 samples_taken, frames_done, results_checked, mismatch_count);
        $display("Covered length saturation, oversized pools, offset extremes, mid-frame cuts.");
        if (mismatch_count == 0) begin
            $display("tb_fractional_max_pool_1d_unit passed");
        end else begin
            $display("tb_fractional_max_pool_1d_unit failed");
        end
        $finish;
    end

endmodule
